/* design/iuv_pkg.sv */
// iuv_pkg: shared types, mixing constants and helper functions for the
// instruction unit decrypt and verify block; no dependencies
`timescale 1ns / 1ps

package iuv_pkg;

   localparam int UNIT_BYTES = 24;

   // mixing constants
   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam logic [63:0] ADDR_SALT = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] KEY_SALT  = 64'hd1b54a32d192ed03;
   localparam logic [63:0] LANE_STEP = 64'h9e3779b185ebca87;

   // magic bytes at the tail of a decrypted unit
   localparam logic [7:0] MAGIC_B0 = 8'h53;
   localparam logic [7:0] MAGIC_B1 = 8'h49;
   localparam logic [7:0] MAGIC_B2 = 8'h4d;

   // status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_KEY_FAIL    = 2'd1;
   localparam logic [1:0] STATUS_TAG_FAIL    = 2'd2;
   localparam logic [1:0] STATUS_DECODE_FAIL = 2'd3;

   // register indexes
   localparam logic REG_KEY_NUMBER = 1'b0;
   localparam logic REG_MAX_OPCODE = 1'b1;

   typedef struct packed {
      logic [63:0] cipher_word_low;
      logic [63:0] cipher_word_mid;
      logic [63:0] cipher_word_high;
      logic [31:0] given_key_check;
      logic [31:0] given_tag;
      logic [63:0] fetch_address;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         opcode;
      logic signed [31:0] dest_reg;
      logic signed [31:0] src1_reg;
      logic signed [31:0] src2_reg;
      logic signed [63:0] immediate;
   } rsp_type;

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
      return (v << amt) | (v >> (64 - amt));
   endfunction

   function automatic logic [31:0] fold_to_32(input logic [63:0] v);
      return v[63:32] ^ v[31:0];
   endfunction

endpackage

/* design/iuv_fold.sv */
// iuv_fold: three-stage pipelined 64-bit mix finalizer over several lanes,
// with a valid bit and a sideband word that travel alongside; uses iuv_pkg
`timescale 1ns / 1ps

module iuv_fold #(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [LANES-1:0][63:0] in_value,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic [LANES-1:0][63:0] out_value,
   output logic [SIDE_W-1:0]      out_side
);
   import iuv_pkg::*;

   logic [LANES-1:0][63:0] x, y, z;
   logic [LANES-1:0][63:0] p_lo_in, p_lo_ff, q_lo_in, q_lo_ff, out_in, out_ff;
   logic [LANES-1:0][31:0] p_x_in, p_x_ff, p_y_in, p_y_ff;
   logic [LANES-1:0][31:0] q_x_in, q_x_ff, q_y_in, q_y_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic [SIDE_W-1:0]      s1_ff, s2_ff, s3_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         // first multiply, split into 32-bit partial products
         x[l]       = in_value[l] ^ (in_value[l] >> 30);
         p_lo_in[l] = {32'd0, x[l][31:0]} * {32'd0, MIX_MUL_A[31:0]};
         p_x_in[l]  = x[l][31:0] * MIX_MUL_A[63:32];
         p_y_in[l]  = x[l][63:32] * MIX_MUL_A[31:0];
         // second multiply
         y[l]       = p_lo_ff[l] + {p_x_ff[l] + p_y_ff[l], 32'd0};
         y[l]       = y[l] ^ (y[l] >> 27);
         q_lo_in[l] = {32'd0, y[l][31:0]} * {32'd0, MIX_MUL_B[31:0]};
         q_x_in[l]  = y[l][31:0] * MIX_MUL_B[63:32];
         q_y_in[l]  = y[l][63:32] * MIX_MUL_B[31:0];
         // final sum and shift mix
         z[l]       = q_lo_ff[l] + {q_x_ff[l] + q_y_ff[l], 32'd0};
         out_in[l]  = z[l] ^ (z[l] >> 31);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_lo_ff <= p_lo_in;
         p_x_ff  <= p_x_in;
         p_y_ff  <= p_y_in;
         s1_ff   <= in_side;
         q_lo_ff <= q_lo_in;
         q_x_ff  <= q_x_in;
         q_y_ff  <= q_y_in;
         s2_ff   <= s1_ff;
         out_ff  <= out_in;
         s3_ff   <= s2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_value = out_ff;
   assign out_side  = s3_ff;

endmodule

/* design/instruction_unit_decrypt_verify.sv */
// instruction_unit_decrypt_verify: top level, key check, tag chain and decode
// depends on iuv_pkg and iuv_fold
`timescale 1ns / 1ps

// usage
// - req channel: one encrypted 24-byte instruction unit per word, with its
//   key check, tag and fetch address; valid/ready handshake
// - rsp channel: one word per request, status plus decoded fields; fields
//   are zero unless status is ok
// - csr port: write-only, index 0 key number, index 1 largest opcode;
//   write only while no word is in flight
// - path: from accept to rsp_valid through the input register, seed mixing,
//   lane prep, key/keystream mixing, capture, 24 tag rounds and the output
//   register
// - throughput: one word per cycle unless stalled; every mix is a three-stage
//   pipeline made of 32x32 partial products, the 24-round tag chain sets the depth
// - stall: when rsp_valid is high and rsp_ready low the whole pipeline
//   holds and req_ready drops; nothing is lost or repeated
// - reset: all valid bits clear, key number 0, largest opcode 255
module instruction_unit_decrypt_verify (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iuv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iuv_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);
   import iuv_pkg::*;

   localparam int LANES_B = UNIT_BYTES + 2;

   // sideband through seed and keystream mixing
   typedef struct packed {
      logic [191:0] ct;
      logic [31:0]  given_key_check;
      logic [31:0]  given_tag;
   } front_type;

   // sideband through the tag chain
   typedef struct packed {
      logic [191:0] ct;
      logic [31:0]  given_tag;
      logic         key_ok;
      logic         dec_ok;
      logic [167:0] fields;
   } chain_type;

   logic        adv;
   logic [31:0] key_nr_ff;
   logic [7:0]  max_op_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_nr_ff <= 32'd0;
         max_op_ff <= 8'hff;
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY_NUMBER: key_nr_ff <= csr_wdata;
            REG_MAX_OPCODE: max_op_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // one shared advance: the pipeline moves unless the output word is stuck
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // input register
   req_type in_ff;
   logic    in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (adv) in_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) in_ff <= req_data;
   end

   // address seed and key seed
   logic [1:0][63:0] a_in, a_out;
   front_type        a_side_in, a_side_out;
   logic             a_valid;

   always_comb begin
      a_in[0] = in_ff.fetch_address ^ ADDR_SALT;
      a_in[1] = {32'd0, key_nr_ff} ^ KEY_SALT;
      a_side_in.ct = {in_ff.cipher_word_high, in_ff.cipher_word_mid, in_ff.cipher_word_low};
      a_side_in.given_key_check = in_ff.given_key_check;
      a_side_in.given_tag       = in_ff.given_tag;
   end

   iuv_fold #(.LANES(2), .SIDE_W($bits(front_type))) u_seed (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(in_valid_ff), .in_value(a_in), .in_side(a_side_in),
      .out_valid(a_valid), .out_value(a_out), .out_side(a_side_out)
   );

   // lane prep: key check input, tag seed input, keystream lane inputs
   logic [LANES_B-1:0][63:0] prep_in, prep_ff;
   front_type                prep_side_ff;
   logic                     prep_valid_ff;

   always_comb begin
      prep_in[0] = {32'd0, key_nr_ff} ^ a_out[0];
      prep_in[1] = a_out[0] ^ rotl64(a_out[1], 9);
      for (int i = 0; i < UNIT_BYTES; i++) begin
         prep_in[i+2] = a_out[0] + rotl64(a_out[1], (i % 7) + 1) + LANE_STEP * 64'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) prep_valid_ff <= 1'b0;
      else if (adv) prep_valid_ff <= a_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prep_ff      <= prep_in;
         prep_side_ff <= a_side_out;
      end
   end

   // key check, tag seed and keystream mixing
   logic [LANES_B-1:0][63:0] b_out;
   front_type                b_side;
   logic                     b_valid;

   iuv_fold #(.LANES(LANES_B), .SIDE_W($bits(front_type))) u_lanes (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(prep_valid_ff), .in_value(prep_ff), .in_side(prep_side_ff),
      .out_valid(b_valid), .out_value(b_out), .out_side(b_side)
   );

   // decrypt, magic and opcode check, key check compare
   logic [191:0] pt;
   chain_type    chain_in, chain_ff;
   logic [63:0]  acc0_ff;
   logic         chain_valid_ff;

   always_comb begin
      for (int i = 0; i < UNIT_BYTES; i++) begin
         pt[8*i +: 8] = b_side.ct[8*i +: 8] ^ b_out[i+2][8*(i % 8) +: 8];
      end
      chain_in.ct        = b_side.ct;
      chain_in.given_tag = b_side.given_tag;
      chain_in.key_ok    = fold_to_32(b_out[0]) == b_side.given_key_check;
      chain_in.dec_ok    = pt[175:168] == MAGIC_B0 && pt[183:176] == MAGIC_B1 &&
                           pt[191:184] == MAGIC_B2 && pt[7:0] <= max_op_ff;
      // opcode, dest, src1, src2, immediate in bytes 0 to 20
      chain_in.fields    = pt[167:0];
   end

   always_ff @(posedge clock) begin
      if (reset) chain_valid_ff <= 1'b0;
      else if (adv) chain_valid_ff <= b_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         chain_ff <= chain_in;
         acc0_ff  <= b_out[1];
      end
   end

   // tag chain: one pipelined mix per ciphertext byte
   logic [63:0] acc_w   [UNIT_BYTES+1];
   chain_type   side_w  [UNIT_BYTES+1];
   logic        valid_w [UNIT_BYTES+1];

   assign acc_w[0]   = acc0_ff;
   assign side_w[0]  = chain_ff;
   assign valid_w[0] = chain_valid_ff;

   for (genvar g = 0; g < UNIT_BYTES; g++) begin : g_round
      logic [0:0][63:0] r_in, r_out;
      logic [63:0]      folded;

      assign folded  = {40'd0, 8'(UNIT_BYTES - g), 8'(g), side_w[g].ct[8*g +: 8]};
      assign r_in[0] = acc_w[g] ^ folded ^ rotl64(acc_w[g], (g % 13) + 1);

      iuv_fold #(.LANES(1), .SIDE_W($bits(chain_type))) u_round (
         .clock(clock), .reset(reset), .en(adv),
         .in_valid(valid_w[g]), .in_value(r_in), .in_side(side_w[g]),
         .out_valid(valid_w[g+1]), .out_value(r_out), .out_side(side_w[g+1])
      );

      assign acc_w[g+1] = r_out[0];
   end

   // status and output register
   rsp_type   rsp_in, rsp_ff;
   logic      rsp_valid_ff;
   chain_type last;

   always_comb begin
      last   = side_w[UNIT_BYTES];
      rsp_in = '0;
      if (!last.key_ok) begin
         rsp_in.status = STATUS_KEY_FAIL;
      end else if (fold_to_32(acc_w[UNIT_BYTES]) != last.given_tag) begin
         rsp_in.status = STATUS_TAG_FAIL;
      end else if (!last.dec_ok) begin
         rsp_in.status = STATUS_DECODE_FAIL;
      end else begin
         rsp_in.status    = STATUS_OK;
         rsp_in.opcode    = last.fields[7:0];
         rsp_in.dest_reg  = last.fields[39:8];
         rsp_in.src1_reg  = last.fields[71:40];
         rsp_in.src2_reg  = last.fields[103:72];
         rsp_in.immediate = last.fields[167:104];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= valid_w[UNIT_BYTES];
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/instruction_unit_decrypt_verify_checker.sv */
// instruction_unit_decrypt_verify_checker: watches the request and response channels,
// predicts each response and compares it; depends on iuv_pkg
`timescale 1ns / 1ps

module instruction_unit_decrypt_verify_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  iuv_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  iuv_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata,
   output int               fail_count,
   output int               pending_count,
   output int               ok_count,
   output int               key_fail_count,
   output int               tag_fail_count,
   output int               decode_fail_count
);
   import iuv_pkg::*;

   logic [31:0] model_key;
   logic [7:0]  model_max_op;
   rsp_type     expected_rsp_q[$];

   function automatic logic [63:0] mix64(input logic [63:0] v);
      logic [63:0] x;
      x = v ^ (v >> 30);
      x = x * MIX_MUL_A;
      x = x ^ (x >> 27);
      x = x * MIX_MUL_B;
      return x ^ (x >> 31);
   endfunction

   function automatic logic [63:0] rol(input logic [63:0] v, input int amt);
      return (v << amt) | (v >> (64 - amt));
   endfunction

   function automatic logic [31:0] fold32(input logic [63:0] v);
      return v[63:32] ^ v[31:0];
   endfunction

   // full decrypt and verify of one unit under the current key settings
   function automatic rsp_type decrypt_unit(input req_type r);
      rsp_type     res;
      logic [63:0] aseed, kseed, acc, lane;
      logic [7:0]  ct[24];
      logic [7:0]  pt[24];
      res   = '0;
      aseed = mix64(r.fetch_address ^ ADDR_SALT);
      kseed = mix64({32'd0, model_key} ^ KEY_SALT);
      for (int i = 0; i < 8; i++) begin
         ct[i]      = r.cipher_word_low[8*i +: 8];
         ct[8 + i]  = r.cipher_word_mid[8*i +: 8];
         ct[16 + i] = r.cipher_word_high[8*i +: 8];
      end
      if (r.given_key_check != fold32(mix64({32'd0, model_key} ^ aseed))) begin
         res.status = STATUS_KEY_FAIL;
         return res;
      end
      acc = mix64(aseed ^ rol(kseed, 9));
      for (int i = 0; i < 24; i++) begin
         acc = mix64(acc ^ ({40'd0, 8'(24 - i), 8'(i), ct[i]}) ^ rol(acc, (i % 13) + 1));
      end
      if (r.given_tag != fold32(acc)) begin
         res.status = STATUS_TAG_FAIL;
         return res;
      end
      for (int i = 0; i < 24; i++) begin
         lane  = mix64(aseed + rol(kseed, (i % 7) + 1) + 64'(i) * LANE_STEP);
         pt[i] = ct[i] ^ lane[(i % 8)*8 +: 8];
      end
      if (pt[21] != MAGIC_B0 || pt[22] != MAGIC_B1 || pt[23] != MAGIC_B2
          || pt[0] > model_max_op) begin
         res.status = STATUS_DECODE_FAIL;
         return res;
      end
      res.status    = STATUS_OK;
      res.opcode    = pt[0];
      res.dest_reg  = {pt[4], pt[3], pt[2], pt[1]};
      res.src1_reg  = {pt[8], pt[7], pt[6], pt[5]};
      res.src2_reg  = {pt[12], pt[11], pt[10], pt[9]};
      res.immediate = {pt[20], pt[19], pt[18], pt[17], pt[16], pt[15], pt[14], pt[13]};
      return res;
   endfunction

   assign pending_count = expected_rsp_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         model_key    <= '0;
         model_max_op <= 8'd255;
         expected_rsp_q.delete();
         fail_count <= 0; ok_count <= 0;
         key_fail_count <= 0; tag_fail_count <= 0; decode_fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_KEY_NUMBER) model_key <= csr_wdata;
            else model_max_op <= csr_wdata[7:0];
         end
         if (req_valid && req_ready) begin
            want = decrypt_unit(req_data);
            expected_rsp_q = {expected_rsp_q, want};
            case (want.status)
               STATUS_OK:       ok_count <= ok_count + 1;
               STATUS_KEY_FAIL: key_fail_count <= key_fail_count + 1;
               STATUS_TAG_FAIL: tag_fail_count <= tag_fail_count + 1;
               default:         decode_fail_count <= decode_fail_count + 1;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected word %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10) begin
                     $display("mismatch: exp st=%0d op=%h rd=%h r1=%h r2=%h imm=%h",
                              want.status, want.opcode, want.dest_reg, want.src1_reg,
                              want.src2_reg, want.immediate);
                     $display("          got st=%0d op=%h rd=%h r1=%h r2=%h imm=%h",
                              rsp_data.status, rsp_data.opcode, rsp_data.dest_reg,
                              rsp_data.src1_reg, rsp_data.src2_reg, rsp_data.immediate);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* tb/instruction_unit_decrypt_verify_tb.sv */
// instruction_unit_decrypt_verify_tb: stimulus and verdict for the decrypt and verify block
// depends on iuv_pkg, the block and instruction_unit_decrypt_verify_checker
`timescale 1ns / 1ps

module instruction_unit_decrypt_verify_tb;
   import iuv_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = REG_KEY_NUMBER;
   logic [31:0] csr_wdata = '0;

   int fail_count, pending_count, ok_count, key_fail_count, tag_fail_count, decode_fail_count;

   // stimulus-side copy of the key number, used to build well-formed units
   logic [31:0] tb_key = '0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   always #5 clock = ~clock;

   instruction_unit_decrypt_verify i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   instruction_unit_decrypt_verify_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending_count, .ok_count, .key_fail_count,
      .tag_fail_count, .decode_fail_count
   );

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // stimulus-side mixing to build units that pass key check and tag
   function automatic logic [63:0] mix64(input logic [63:0] v);
      logic [63:0] x;
      x = v ^ (v >> 30);
      x = x * MIX_MUL_A;
      x = x ^ (x >> 27);
      x = x * MIX_MUL_B;
      return x ^ (x >> 31);
   endfunction

   function automatic logic [63:0] rol(input logic [63:0] v, input int amt);
      return (v << amt) | (v >> (64 - amt));
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // kind: 0 good unit, 1 bad magic, 3 bad tag, 4 bad key check, 5 noise; 2 also builds a good unit
   function automatic req_type build_unit(input int kind, input logic [63:0] addr,
                                          input logic [7:0] op, input logic [127:0] body);
      req_type     r;
      logic [63:0] aseed, kseed, acc, lane, kmix;
      logic [7:0]  pt[24];
      logic [7:0]  ct[24];
      aseed = mix64(addr ^ ADDR_SALT);
      kseed = mix64({32'd0, tb_key} ^ KEY_SALT);
      pt[0] = op;
      for (int i = 1; i < 21; i++) pt[i] = (i <= 16) ? body[8*(i-1) +: 8] : 8'($urandom());
      pt[21] = MAGIC_B0; pt[22] = MAGIC_B1; pt[23] = MAGIC_B2;
      if (kind == 1) pt[21 + $urandom_range(2)] ^= 8'(1 << $urandom_range(7));
      for (int i = 0; i < 24; i++) begin
         lane  = mix64(aseed + rol(kseed, (i % 7) + 1) + 64'(i) * LANE_STEP);
         ct[i] = pt[i] ^ lane[(i % 8)*8 +: 8];
      end
      acc = mix64(aseed ^ rol(kseed, 9));
      for (int i = 0; i < 24; i++)
         acc = mix64(acc ^ ({40'd0, 8'(24 - i), 8'(i), ct[i]}) ^ rol(acc, (i % 13) + 1));
      for (int i = 0; i < 8; i++) begin
         r.cipher_word_low[8*i +: 8]  = ct[i];
         r.cipher_word_mid[8*i +: 8]  = ct[8 + i];
         r.cipher_word_high[8*i +: 8] = ct[16 + i];
      end
      r.fetch_address   = addr;
      kmix              = mix64({32'd0, tb_key} ^ aseed);
      r.given_key_check = kmix[63:32] ^ kmix[31:0];
      r.given_tag = acc[63:32] ^ acc[31:0];
      if (kind == 3) r.given_tag ^= 32'(1) << $urandom_range(31);
      if (kind == 4) r.given_key_check ^= 32'(1) << $urandom_range(31);
      if (kind == 5) begin
         r.cipher_word_low = rand64(); r.cipher_word_mid = rand64();
         r.cipher_word_high = rand64(); r.given_key_check = $urandom();
         r.given_tag = $urandom();
      end
      return r;
   endfunction

   // valid stays high from one word to the next unless the sender idles
   task automatic send_word(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random_unit();
      int          pick;
      int          kind;
      logic [7:0]  op;
      pick = $urandom_range(99);
      kind = (pick < 70) ? 0 : (pick < 78) ? 1 : (pick < 86) ? 3 : (pick < 94) ? 4 : 5;
      op   = $urandom();
      send_word(build_unit(kind, rand64(), op, {rand64(), rand64()}));
   endtask

   // let every in-flight word drain, then keep idling before returning
   task automatic drain_pipe();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_KEY_NUMBER) tb_key = val;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes, each failure class
      send_word(build_unit(0, 64'd0, 8'h00, '0));
      send_word(build_unit(0, '1, 8'hff, '1));
      send_word(build_unit(0, 64'h8000_0000_0000_0000, 8'h80, {64'h8000_0000_0000_0000,
                64'h8000_0000_8000_0000}));
      send_word(build_unit(1, 64'h1234, 8'h01, '0));
      send_word(build_unit(3, 64'h5678, 8'h02, '1));
      send_word(build_unit(4, 64'h9abc, 8'h03, '0));
      send_word(build_unit(5, '1, 8'h00, '0));
      send_word('1);
      drain_pipe();

      write_reg(REG_MAX_OPCODE, 32'd0);
      write_reg(REG_KEY_NUMBER, 32'hffff_ffff);
      send_word(build_unit(0, 64'd7, 8'h00, '1));   // opcode at the bound
      send_word(build_unit(0, 64'd8, 8'h01, '1));   // just above the bound
      send_word(build_unit(0, 64'd9, 8'hff, '0));
      drain_pipe();

      write_reg(REG_MAX_OPCODE, 32'hffff_ff7f);     // upper bits dropped
      write_reg(REG_KEY_NUMBER, 32'h8000_0000);
      send_word(build_unit(0, 64'd10, 8'h7f, '0));
      send_word(build_unit(0, 64'd11, 8'h80, '0));
      drain_pipe();

      // random phases: each idling mix under its own key settings
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(REG_KEY_NUMBER, (ph == 0) ? 32'd0 : $urandom());
         write_reg(REG_MAX_OPCODE, (ph == 3) ? 32'd255 : $urandom_range(255, 64));
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         for (int n = 0; n < 125; n++) begin
            send_random_unit();
            // hold off once until everything has come back
            if (ph == 1 && n == 60) drain_pipe();
         end
         drain_pipe();
      end

      $display("covered %0d ok, %0d key check, %0d tag and %0d decode failures",
               ok_count, key_fail_count, tag_fail_count, decode_fail_count);
      $display("across four idling mixes and several key and opcode-bound settings");
      if (fail_count == 0 && pending_count == 0) begin
         $display("instruction_unit_decrypt_verify_tb: done, clean");
      end else begin
         $display("instruction_unit_decrypt_verify_tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("instruction_unit_decrypt_verify_tb: done, errors");
      $finish;
   end
endmodule
